>>> hdl/crc16cf_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the command framer.
// No dependencies; used by crc16_command_framer and its checker.
`timescale 1ns / 1ps
`default_nettype none

package crc16cf_pkg;

	// Frame constants.
	localparam logic [7:0]  HDR0        = 8'hAA;
	localparam logic [7:0]  HDR1        = 8'h55;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  MAX_PAYLOAD = 8'd250;

	// Input operation codes.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	// Error codes carried in a result.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG = 2'd1;
	localparam logic [1:0] ERR_STRAY    = 2'd2;

	// One input item can give at most this many result bytes.
	localparam int OUT_DEPTH = 6;
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic       func;
		logic [7:0] command;
		logic [7:0] payload_length;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic [1:0] error_code;
	} result_t;

	// One byte through the reflected CRC-16/MODBUS polynomial.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/crc16_command_framer.sv
// Command frame encoder: header, length, command, payload and CRC-16/MODBUS trailer.
// Depends on crc16cf_pkg for the item and result types and the CRC byte step.
//
// Usage:
//   The item channel (item_valid, item_stall, item) takes start and payload items.
//   The result channel (result_valid, result_stall, result) gives one frame byte
//   per transfer. The cfg channel (cfg_valid, cfg_ready, cfg_data) writes
//   length_mode; cfg_ready is always high. The user must write length_mode only
//   while idle; the block itself does not enforce this. An accepted item is
//   registered in the input register, then its 1 to 6 result bytes are built
//   combinationally and loaded into a small output buffer, whose head is shown.
//   An item leaves the input register once the buffer holds at most its last byte
//   being taken, so the buffer drain sets the pace: a payload byte in mid frame
//   gives one result byte, the last payload byte three, a start four, a start
//   with empty payload six and an error result one. Reset clears the buffer and
//   input register, closes any frame, sets the CRC to 0xFFFF and length_mode to 0.
//   While the receiver stalls, the shown byte holds; while the buffer cannot take
//   the held item, item_stall is high and the input register holds.
`timescale 1ns / 1ps
`default_nettype none

module crc16_command_framer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  crc16cf_pkg::item_t   item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output crc16cf_pkg::result_t result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire                  cfg_data
);

	localparam int CW = crc16cf_pkg::CNT_W;
	localparam int OD = crc16cf_pkg::OUT_DEPTH;

	logic                 valid_s1;
	crc16cf_pkg::item_t   item_s1;
	logic                 length_mode_q;
	logic [15:0]          crc_q;
	logic [7:0]           remain_q;
	logic                 open_q;
	logic [CW-1:0]        cnt_q;
	crc16cf_pkg::result_t obuf_q [OD];

	logic                 take;
	logic                 load_ok;
	logic                 advance;
	logic                 accept;
	crc16cf_pkg::result_t new_buf [OD];
	logic [CW-1:0]        new_cnt;
	logic [15:0]          new_crc;
	logic [7:0]           new_remain;
	logic                 new_open;

	assign cfg_ready    = 1'b1;
	assign result_valid = (cnt_q != '0);
	assign result       = obuf_q[0];
	assign take         = result_valid && !result_stall;
	// The buffer can take a new item when empty or when its last byte leaves now.
	assign load_ok      = (cnt_q == '0) || ((cnt_q == CW'(1)) && take);
	assign advance      = valid_s1 && load_ok;
	assign item_stall   = valid_s1 && !load_ok;
	assign accept       = item_valid && !item_stall;

	always_comb begin
		logic [7:0]  lenb;
		logic [15:0] crc_a;
		logic [15:0] crc_b;
		logic [7:0]  rem_dec;
		for (int i = 0; i < OD; i++) begin
			new_buf[i] = '0;
		end
		new_cnt    = '0;
		new_crc    = crc_q;
		new_remain = remain_q;
		new_open   = open_q;
		lenb       = length_mode_q ? item_s1.payload_length : item_s1.payload_length + 8'd1;
		crc_a      = crc16cf_pkg::crc16_byte(crc16cf_pkg::CRC_INIT, lenb);
		crc_b      = crc16cf_pkg::crc16_byte(crc_a, item_s1.command);
		rem_dec    = (remain_q != 8'd0) ? remain_q - 8'd1 : 8'd0;
		if (item_s1.func == crc16cf_pkg::FUNC_START) begin
			new_open   = 1'b0;
			new_remain = 8'd0;
			if (item_s1.payload_length > crc16cf_pkg::MAX_PAYLOAD) begin
				new_buf[0] = '{8'h00, 1'b1, crc16cf_pkg::ERR_TOO_LONG};
				new_cnt    = CW'(1);
			end else begin
				new_crc    = crc_b;
				new_buf[0] = '{crc16cf_pkg::HDR0, 1'b0, crc16cf_pkg::ERR_NONE};
				new_buf[1] = '{crc16cf_pkg::HDR1, 1'b0, crc16cf_pkg::ERR_NONE};
				new_buf[2] = '{lenb, 1'b0, crc16cf_pkg::ERR_NONE};
				new_buf[3] = '{item_s1.command, 1'b0, crc16cf_pkg::ERR_NONE};
				if (item_s1.payload_length == 8'd0) begin
					new_buf[4] = '{crc_b[7:0], 1'b0, crc16cf_pkg::ERR_NONE};
					new_buf[5] = '{crc_b[15:8], 1'b1, crc16cf_pkg::ERR_NONE};
					new_cnt    = CW'(6);
				end else begin
					new_open   = 1'b1;
					new_remain = item_s1.payload_length;
					new_cnt    = CW'(4);
				end
			end
		end else if (!open_q) begin
			new_buf[0] = '{8'h00, 1'b1, crc16cf_pkg::ERR_STRAY};
			new_cnt    = CW'(1);
		end else begin
			new_crc    = crc16cf_pkg::crc16_byte(crc_q, item_s1.data_byte);
			new_buf[0] = '{item_s1.data_byte, 1'b0, crc16cf_pkg::ERR_NONE};
			new_remain = rem_dec;
			new_cnt    = CW'(1);
			if (rem_dec == 8'd0) begin
				// Last payload byte: append the CRC, low byte first.
				new_buf[1] = '{new_crc[7:0], 1'b0, crc16cf_pkg::ERR_NONE};
				new_buf[2] = '{new_crc[15:8], 1'b1, crc16cf_pkg::ERR_NONE};
				new_cnt    = CW'(3);
				new_open   = 1'b0;
				new_remain = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			length_mode_q <= 1'b0;
			crc_q         <= crc16cf_pkg::CRC_INIT;
			remain_q      <= 8'd0;
			open_q        <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				length_mode_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				crc_q    <= new_crc;
				remain_q <= new_remain;
				open_q   <= new_open;
				cnt_q    <= new_cnt;
			end else if (take) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (advance) begin
			obuf_q <= new_buf;
		end else if (take) begin
			for (int i = 0; i < OD - 1; i++) begin
				obuf_q[i] <= obuf_q[i + 1];
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/crc16cf_checker.sv
// Port-level checks for crc16_command_framer, attached by the bind at the end.
// Depends on crc16cf_pkg for the result type and error codes.
`timescale 1ns / 1ps
`default_nettype none

module crc16cf_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  item_valid,
	input wire                  item_stall,
	input crc16cf_pkg::item_t   item,
	input wire                  result_valid,
	input wire                  result_stall,
	input crc16cf_pkg::result_t result,
	input wire                  cfg_valid,
	input wire                  cfg_ready,
	input wire                  cfg_data
);

	// A stalled result holds until its transfer.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A held-off item keeps its valid and its payload until its transfer.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("item changed while stalled");

	// The input may only be held off while bytes are waiting at the output.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item_stall high with no result pending");

	// An error result is a single zero byte that closes the frame.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.error_code != crc16cf_pkg::ERR_NONE)
		|-> result.frame_end && (result.out_byte == 8'h00))
		else $error("malformed error result");

	// A configuration write is always taken and carries a known value.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
		else $error("configuration write not taken or unknown");

endmodule

bind crc16_command_framer crc16cf_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_data     (cfg_data)
);

`default_nettype wire
